### src/dqvd_pkg.sv
// dqvd_pkg: shared constants, codes, word types and helpers for the deque block
// used by dqvd_cell and deque_with_value_delete; no dependencies
package dqvd_pkg;

	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [3:0] {
		CMD_ADD_FIRST  = 4'd0,
		CMD_ADD_LAST   = 4'd1,
		CMD_DEL_FIRST  = 4'd2,
		CMD_DEL_LAST   = 4'd3,
		CMD_DEL_VALUE  = 4'd4,
		CMD_LIST_ALL   = 4'd5,
		CMD_LIST_FIRST = 4'd6,
		CMD_LIST_LAST  = 4'd7,
		CMD_CLEAR      = 4'd8
	} cmd_t;

	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_ELEMENT = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] value;
		logic [5:0]         count;
	} req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] element;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic          shl;
		logic          shr;
		logic          ins;
		logic [IW-1:0] idx;
	} cell_ctrl_t;

	function automatic data_t to_store(logic signed [31:0] v);
		logic signed [DATA_WIDTH+31:0] ext;
		begin
			ext = (DATA_WIDTH + 32)'(v);
			return ext[DATA_WIDTH-1:0];
		end
	endfunction

	function automatic logic signed [31:0] to_elem(data_t d);
		logic signed [DATA_WIDTH+31:0] ext;
		begin
			ext = (DATA_WIDTH + 32)'($signed(d));
			return ext[31:0];
		end
	endfunction

endpackage

### src/dqvd_cell.sv
// dqvd_cell: one storage slot of the entry chain
// depends on dqvd_pkg
module dqvd_cell import dqvd_pkg::*; (
	input  logic          clk,
	input  cell_ctrl_t    ctrl,
	input  logic [IW-1:0] position,
	input  data_t         left,
	input  data_t         right,
	input  data_t         bcast,
	output data_t         data
);

	data_t data_q;
	logic  hit;

	assign hit  = ctrl.ins && (ctrl.idx == position);
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			data_q <= hit ? bcast : right;
		end else if (ctrl.shr) begin
			data_q <= left;
		end else if (hit) begin
			data_q <= bcast;
		end
	end

endmodule

### src/deque_with_value_delete.sv
// deque_with_value_delete: bounded deque held in a chain of slot cells
// end commands, add, clear: done in idle; delete by value: walk over occupied slots; listings:
// whole ring rotation plus output stalls; next word taken at the edge the result word leaves
// arst_n clears the list to empty; slot contents are not reset
// depends on dqvd_pkg and dqvd_cell
module deque_with_value_delete import dqvd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_LIST = 3'b100
	} state_t;

	state_t        state_q;
	logic [CW-1:0] occ_q, j_q, w_q, start_q, n_q;
	data_t         val_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	data_t         data [CAPACITY];
	cell_ctrl_t    ctrl;
	data_t         bcast;

	logic          fire, keep, emit, adv, out_free;
	logic [CW:0]   ins_full, rel;
	logic [CW-1:0] n_sat;
	data_t         req_val;

	logic          walk_go, list_go, rsp_load;
	logic [CW-1:0] list_n;
	rsp_t          rsp_d;

	assign req_val   = to_store(req.value);
	assign fire      = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign keep     = data[0] != val_q;
	assign ins_full = {1'b0, occ_q} - (CW+1)'(1) - {1'b0, j_q} + {1'b0, w_q};
	assign rel      = {1'b0, j_q} - {1'b0, start_q};
	assign emit     = (j_q >= start_q) && (rel < {1'b0, n_q});
	assign adv      = !emit || out_free;

	always_comb begin
		if (({{CW{1'b0}}, req.count}) < ({6'b0, occ_q})) begin
			n_sat = CW'(req.count);
		end else begin
			n_sat = occ_q;
		end
	end

	assign list_n  = (req.command == CMD_LIST_ALL) ? occ_q : n_sat;
	assign walk_go = (req.command == CMD_DEL_VALUE) && (occ_q != '0);
	assign list_go = (req.command == CMD_LIST_ALL || req.command == CMD_LIST_FIRST
		|| req.command == CMD_LIST_LAST) && (list_n != '0);

	assign bcast = (state_q == S_WALK) ? data[0] : req_val;

	always_comb begin
		ctrl = '0;
		case (state_q)
			S_IDLE: begin
				if (fire) begin
					case (req.command)
						CMD_ADD_FIRST: ctrl.shr = occ_q < CW'(CAPACITY);
						CMD_ADD_LAST: begin
							ctrl.ins = occ_q < CW'(CAPACITY);
							ctrl.idx = occ_q[IW-1:0];
						end
						CMD_DEL_FIRST: ctrl.shl = occ_q != '0;
						default: ;
					endcase
				end
			end
			S_WALK: begin
				ctrl.shl = 1'b1;
				ctrl.ins = keep;
				ctrl.idx = ins_full[IW-1:0];
			end
			S_LIST: ctrl.shl = adv;
			default: ;
		endcase
	end

	always_comb begin
		rsp_load = 1'b0;
		rsp_d    = '{KIND_STATUS, 32'sd0, ST_DONE, 1'b1};
		case (state_q)
			S_IDLE: begin
				rsp_load = fire && !walk_go && !list_go;
				case (req.command)
					CMD_ADD_FIRST, CMD_ADD_LAST: begin
						if (occ_q >= CW'(CAPACITY)) begin
							rsp_d.status = ST_FULL;
						end
					end
					CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_VALUE: begin
						if (occ_q == '0) begin
							rsp_d.status = ST_EMPTY;
						end
					end
					CMD_LIST_ALL, CMD_LIST_FIRST, CMD_LIST_LAST: rsp_d.kind = KIND_EMPTY;
					default: ;
				endcase
			end
			S_WALK: rsp_load = (j_q == occ_q - CW'(1));
			S_LIST: begin
				if (adv && emit) begin
					rsp_load = 1'b1;
					rsp_d    = '{KIND_ELEMENT, to_elem(data[0]), ST_DONE,
						rel == {1'b0, n_q - CW'(1)}};
				end
			end
			default: ;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			dqvd_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.position (IW'(gi)),
				.left     ((gi == 0) ? bcast : data[(gi + CAPACITY - 1) % CAPACITY]),
				.right    (data[(gi + 1) % CAPACITY]),
				.bcast    (bcast),
				.data     (data[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && fire) begin
			val_q <= req_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= rsp_d;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			j_q     <= '0;
			w_q     <= '0;
			start_q <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (fire) begin
						j_q     <= '0;
						w_q     <= '0;
						start_q <= (req.command == CMD_LIST_LAST) ? occ_q - n_sat : '0;
						case (req.command)
							CMD_ADD_FIRST, CMD_ADD_LAST: begin
								if (occ_q < CW'(CAPACITY)) begin
									occ_q <= occ_q + CW'(1);
								end
							end
							CMD_DEL_FIRST, CMD_DEL_LAST: begin
								if (occ_q != '0) begin
									occ_q <= occ_q - CW'(1);
								end
							end
							CMD_DEL_VALUE: begin
								if (walk_go) begin
									state_q <= S_WALK;
								end
							end
							CMD_LIST_ALL, CMD_LIST_FIRST, CMD_LIST_LAST: begin
								if (list_go) begin
									state_q <= S_LIST;
									n_q     <= list_n;
								end
							end
							CMD_CLEAR: occ_q <= '0;
							default: ;
						endcase
					end
				end
				S_WALK: begin
					j_q <= j_q + CW'(1);
					w_q <= w_q + CW'(keep);
					if (j_q == occ_q - CW'(1)) begin
						occ_q   <= w_q + CW'(keep);
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (adv) begin
						if (j_q == CW'(CAPACITY - 1)) begin
							state_q <= S_IDLE;
						end else begin
							j_q <= j_q + CW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.command == CMD_ADD_LAST || req.command == CMD_ADD_FIRST)
		&& occ_q < CW'(CAPACITY) |=> occ_q == $past(occ_q) + CW'(1))
		else $error("add did not grow the list");

	a_walk_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> !rsp_valid_q && !req_ready)
		else $error("result or accept during value delete");

endmodule
